// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by lkvc_cell and lru_key_value_cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [DATA_W-1:0] SET_VALUE  = 32'sd0;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic step;
        logic op_set;
        logic any_hit;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one beat per cycle while the result beat is not stalled, set by the compare
// and shift along the row of recency cells.
// Reset: store emptied, capacity ENTRIES; a capacity write also empties it.
// Top level of the LRU key/value cache; depends on lkvc_pkg and lkvc_cell.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire        [lkvc_pkg::CAP_W-1:0]        i_cfg_data,
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire                                     i_op,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]  i_key,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic                                    o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]      o_read_value
);
    import lkvc_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    logic [CW-1:0]            r_cap;
    logic [CW-1:0]            n_cap;
    logic                     r_out_valid;
    logic                     r_hit;
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] n_rdata;
    logic                     w_accept;
    logic                     w_cfg_wr;
    t_entry                   w_head;
    t_cell_ctl                w_ctl;
    t_entry                   w_entry    [ENTRIES];
    logic [ENTRIES-1:0]       w_match;
    logic [ENTRIES-1:0]       w_valid;
    logic [ENTRIES-1:0]       w_keep;
    logic [ENTRIES:0]         w_hit_fwd;
    logic signed [DATA_W-1:0] w_hit_data [ENTRIES+1];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CW'(1);
        end else if (32'(i_cfg_data) > 32'(ENTRIES)) begin
            n_cap = CW'(ENTRIES);
        end else begin
            n_cap = CW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CW'(ENTRIES);
        end else if (w_cfg_wr) begin
            r_cap <= n_cap;
        end
    end

    assign w_hit_fwd[ENTRIES]  = 1'b0;
    assign w_hit_data[ENTRIES] = '0;

    assign w_ctl = '{step: w_accept, op_set: (i_op == OP_SET), any_hit: w_hit_fwd[0]};

    assign w_head = '{valid: 1'b1, key: i_key,
                      data: (i_op == OP_SET) ? i_value : w_hit_data[0]};

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_prev;

        if (g == 0) begin : g_head
            assign w_prev = w_head;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end

        assign w_keep[g]  = (32'(g) < 32'(r_cap));
        assign w_valid[g] = w_entry[g].valid;

        lkvc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (w_cfg_wr),
            .i_ctl      (w_ctl),
            .i_keep     (w_keep[g]),
            .i_prev     (w_prev),
            .i_key      (i_key),
            .i_hit_fwd  (w_hit_fwd[g+1]),
            .i_hit_data (w_hit_data[g+1]),
            .o_entry    (w_entry[g]),
            .o_match    (w_match[g]),
            .o_hit_fwd  (w_hit_fwd[g]),
            .o_hit_data (w_hit_data[g])
        );
    end

    always_comb begin
        if (i_op == OP_SET) begin
            n_rdata = SET_VALUE;
        end else if (w_hit_fwd[0]) begin
            n_rdata = w_hit_data[0];
        end else begin
            n_rdata = MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit   <= w_hit_fwd[0];
            r_rdata <= n_rdata;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key held by more than one cell");

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid cells not packed towards the head");

    a_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) <= 32'(r_cap))
        else $error("more valid entries than capacity");
`endif

endmodule

`default_nettype wire

// ----- rtl/lkvc_cell.sv -----
// One recency slot of the LRU cache: holds an entry, compares it against the
// probe key and takes its neighbour's entry on a shift. Depends on lkvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_clear,
    input  wire lkvc_pkg::t_cell_ctl              i_ctl,
    input  wire                                   i_keep,
    input  wire lkvc_pkg::t_entry                 i_prev,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]  i_key,
    input  wire                                   i_hit_fwd,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] i_hit_data,
    output lkvc_pkg::t_entry                      o_entry,
    output logic                                  o_match,
    output logic                                  o_hit_fwd,
    output logic signed [lkvc_pkg::DATA_W-1:0]    o_hit_data
);
    import lkvc_pkg::*;

    logic                     r_valid;
    logic signed [KEY_W-1:0]  r_key;
    logic signed [DATA_W-1:0] r_data;
    logic                     w_shift;

    assign o_match    = r_valid && (r_key == i_key);
    assign o_hit_fwd  = i_hit_fwd | o_match;
    assign o_hit_data = i_hit_data | (o_match ? r_data : '0);

    // shift when the hit lies here or further down, or on an insert
    assign w_shift = i_ctl.step & (o_hit_fwd | (i_ctl.op_set & ~i_ctl.any_hit));

    assign o_entry = '{valid: r_valid, key: r_key, data: r_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev.valid & i_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key  <= i_prev.key;
            r_data <= i_prev.data;
        end
    end

endmodule

`default_nettype wire

// ----- tb/lkvc_checker.sv -----
// Scoreboard for the LRU key/value cache: watches the capacity, request and reply beats.
// Keeps its own copy of the store and ranks, and compares every reply in order.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_checker (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_valid,
    input  wire                                     i_cfg_ready,
    input  wire        [lkvc_pkg::CAP_W-1:0]        i_cfg_data,
    input  wire                                     i_in_valid,
    input  wire                                     i_in_stall,
    input  wire                                     i_op,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]  i_key,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    input  wire                                     i_out_valid,
    input  wire                                     i_out_stall,
    input  wire                                     i_hit,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] i_read_value,
    output int                                      o_fail_count,
    output int                                      o_pending,
    output int                                      o_checked,
    output int                                      o_hits,
    output int                                      o_evictions
);
    import lkvc_pkg::*;

    localparam int SLOTS = DEF_ENTRIES;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } t_reply;

    logic [CAP_W-1:0]         capacity;
    logic                     slot_valid [SLOTS];
    logic signed [KEY_W-1:0]  slot_key   [SLOTS];
    logic signed [DATA_W-1:0] slot_data  [SLOTS];
    int                       slot_rank  [SLOTS];
    t_reply                   replies_due[$];

    task automatic empty_store();
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_rank[i]  = 0;
        end
    endtask

    // move slot idx to the front; anything more recent than it drops back one place
    function automatic void make_most_recent(input int idx);
        int old_rank;
        old_rank = slot_rank[idx];
        for (int i = 0; i < SLOTS; i++)
            if (i != idx && slot_valid[i] && slot_rank[i] < old_rank)
                slot_rank[i]++;
        slot_rank[idx] = 0;
    endfunction

    function automatic t_reply cache_access(input logic op,
                                            input logic signed [KEY_W-1:0] k,
                                            input logic signed [DATA_W-1:0] v);
        int     found;
        int     used;
        int     limit;
        int     victim;
        int     free_slot;
        t_reply r;
        found     = -1;
        used      = 0;
        victim    = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i]) begin
                used++;
                if (found < 0 && slot_key[i] == k)
                    found = i;
            end
        if (op == OP_GET) begin
            if (found >= 0) begin
                make_most_recent(found);
                r.hit        = 1'b1;
                r.read_value = slot_data[found];
            end else begin
                r.hit        = 1'b0;
                r.read_value = MISS_VALUE;
            end
            return r;
        end
        r.read_value = SET_VALUE;
        if (found >= 0) begin
            slot_data[found] = v;
            make_most_recent(found);
            r.hit = 1'b1;
            return r;
        end
        r.hit = 1'b0;
        limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
        if (used >= limit) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                    victim = i;
            if (victim >= 0) begin
                slot_valid[victim] = 1'b0;
                slot_rank[victim]  = 0;
                o_evictions++;
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && !slot_valid[i])
                free_slot = i;
        if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = k;
            slot_data[free_slot]  = v;
            slot_rank[free_slot]  = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        o_fail_count++;
        $display("mismatch at %0t ns: %s, expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            capacity = CAP_W'(DEF_ENTRIES);
            empty_store();
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
                empty_store();
            end
            if (i_in_valid && !i_in_stall)
                replies_due.push_back(cache_access(i_op, i_key, i_value));
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("reply beat with nothing outstanding", '0, i_read_value);
                end else begin
                    want = replies_due.pop_front();
                    o_checked++;
                    if (want.hit)
                        o_hits++;
                    if (i_hit !== want.hit)
                        report_mismatch("hit flag", DATA_W'(want.hit), DATA_W'(i_hit));
                    if (i_read_value !== want.read_value)
                        report_mismatch("read value", want.read_value, i_read_value);
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// ----- tb/tb_lru_key_value_cache.sv -----
// Top-level bench for lru_key_value_cache: clock, reset, capacity writes and request beats.
// Replies are checked by lkvc_checker; depends on lkvc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_valid  = 1'b0;
    logic [CAP_W-1:0]         i_cfg_data   = '0;
    logic                     i_in_valid   = 1'b0;
    logic                     i_op         = OP_GET;
    logic signed [KEY_W-1:0]  i_key        = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic                     i_out_stall  = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_hit;
    logic signed [DATA_W-1:0] o_read_value;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int evictions;
    int cfg_writes     = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;

    logic signed [KEY_W-1:0] key_pool[$];

    lru_key_value_cache u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    lkvc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_hit        (o_hit),
        .i_read_value (o_read_value),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_evictions  (evictions)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d replies outstanding", pending);
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(5, 30);
        return $urandom_range(1, 3);
    endfunction

    // reply side: random back-pressure, plus one long hold when requested
    initial begin : reply_side
        int gap;
        gap = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                rx_hold_cycles--;
            end else if (gap > 0) begin
                i_out_stall <= 1'b1;
                gap--;
            end else begin
                i_out_stall <= 1'b0;
                gap = pick_gap(rx_idle_pct);
            end
        end
    end

    // returns at the rising edge that takes the beat; valid stays high for the next one
    task automatic send_beat(input logic op, input logic signed [KEY_W-1:0] k,
                             input logic signed [DATA_W-1:0] v);
        int gap;
        gap = pick_gap(tx_idle_pct);
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= k;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (2) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            default: return $urandom;
        endcase
    endfunction

    // hold-off: 1 = long reply hold mid-phase, 2 = sender pause until drained mid-phase
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int beats, input int tx_pct,
                             input int rx_pct, input int hold_off);
        int                       room;
        logic                     op;
        logic signed [KEY_W-1:0]  k;
        logic signed [DATA_W-1:0] v;
        write_capacity(cap);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        room = (cap == 0) ? 1 : ((cap > DEF_ENTRIES) ? DEF_ENTRIES : int'(cap));
        key_pool.delete();
        repeat (room + $urandom_range(1, room + 2))
            key_pool.push_back(pick_word());
        for (int n = 0; n < beats; n++) begin
            op = $urandom_range(0, 1) ? OP_SET : OP_GET;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = $urandom;
            v = pick_word();
            send_beat(op, k, v);
            if (n == beats / 2 && hold_off == 1)
                rx_hold_cycles = 80;
            if (n == beats / 2 && hold_off == 2)
                wait_drained();
        end
    endtask

    initial begin : request_side
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, extreme keys and values, update of a present key
        send_beat(OP_GET, 32'sd0, 32'sd5);
        send_beat(OP_SET, KEY_MAX, KEY_MIN);
        send_beat(OP_SET, KEY_MIN, KEY_MAX);
        send_beat(OP_SET, 32'sd0, -32'sd1);
        send_beat(OP_SET, -32'sd1, 32'sd0);
        send_beat(OP_GET, KEY_MAX, 32'sd0);
        send_beat(OP_GET, KEY_MIN, 32'sd0);
        send_beat(OP_GET, -32'sd1, 32'sd0);
        send_beat(OP_GET, 32'sd1, 32'sd0);
        send_beat(OP_SET, 32'sd0, 32'sh1234_5678);
        send_beat(OP_GET, 32'sd0, 32'sd0);

        // two entries: a get refreshes recency, inserts evict the least recent
        write_capacity(CAP_W'(2));
        send_beat(OP_SET, 32'sd10, 32'sd100);
        send_beat(OP_SET, 32'sd20, 32'sd200);
        send_beat(OP_GET, 32'sd10, 32'sd0);
        send_beat(OP_SET, 32'sd30, 32'sd300);
        send_beat(OP_GET, 32'sd20, 32'sd0);
        send_beat(OP_GET, 32'sd10, 32'sd0);
        send_beat(OP_SET, 32'sd10, 32'sd111);
        send_beat(OP_SET, 32'sd40, 32'sd400);
        send_beat(OP_GET, 32'sd30, 32'sd0);
        send_beat(OP_GET, 32'sd10, 32'sd0);

        // zero capacity behaves as one entry
        write_capacity(CAP_W'(0));
        send_beat(OP_SET, 32'sd7, 32'sd70);
        send_beat(OP_SET, 32'sd8, 32'sd80);
        send_beat(OP_GET, 32'sd7, 32'sd0);
        send_beat(OP_GET, 32'sd8, 32'sd0);

        run_phase(CAP_W'(16), 93, 0, 0, 0);
        run_phase(CAP_W'(1), 93, 30, 30, 0);
        run_phase(CAP_W'(31), 93, 40, 20, 0);
        run_phase(CAP_W'(3), 93, 5, 20, 1);
        run_phase(CAP_W'(8), 93, 20, 50, 0);
        run_phase(CAP_W'(17), 93, 50, 10, 0);
        run_phase(CAP_W'(2), 93, 25, 25, 2);
        run_phase(CAP_W'(12), 93, 0, 40, 0);
        run_phase(CAP_W'(5), 93, 35, 0, 0);
        run_phase(CAP_W'(16), 93, 20, 20, 1);

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("checked %0d replies (%0d hits, %0d evictions) across %0d capacity writes",
                 checked, hits, evictions, cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
